FILE: hw/rtl/omfw_pkg.sv
package omfw_pkg;

  typedef enum logic [1:0] {
    OP_CREATE  = 2'd0,
    OP_DESTROY = 2'd1,
    OP_LOCK    = 2'd2,
    OP_UNLOCK  = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_OK            = 3'd0,
    ST_NONE_FREE     = 3'd1,
    ST_NOT_ALLOC     = 3'd2,
    ST_NOT_OWNER     = 3'd3,
    ST_HAS_WAITERS   = 3'd4,
    ST_ALREADY_YOURS = 3'd5,
    ST_NOT_LOCKED    = 3'd6
  } status_e;

  localparam int ID_SLOTS = 16;

  localparam logic [5:0]        OWNER_NONE = 6'd63;
  localparam logic signed [5:0] COUNT_FREE = 6'sd1;
  localparam logic signed [5:0] COUNT_MIN  = 6'sb100000;
  localparam logic signed [5:0] COUNT_ZERO = 6'sd0;
  localparam logic signed [5:0] COUNT_ONE_WAITER = 6'sb111111;

  typedef struct packed {
    op_e        op;
    logic [3:0] mutex_id;
    logic [4:0] caller_task;
  } req_t;

  typedef struct packed {
    status_e    status;
    logic       blocked;
    logic [3:0] created_id;
    logic       woken_valid;
    logic [4:0] woken_task;
  } rsp_t;

endpackage

FILE: hw/rtl/owned_mutex_fifo_waiters.sv
// Channel   Handshake              Payload
// request   start (busy is 0)      req : req_t (op, mutex_id, caller_task)
// response  done, one cycle        rsp : rsp_t (status, blocked, created_id,
//                                        woken_valid, woken_task)
//
// One word per cycle in, one per cycle out; each response goes through the
// request register and then the response register, which is loaded at the
// edge that updates the table, before it is on the ports.
// Synchronous reset clears the in-use flags, counts and owners.
// busy stays low; the receiver cannot stall and takes each word on done.
module owned_mutex_fifo_waiters import omfw_pkg::*; #(
  parameter int MUTEX_COUNT = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  req_t req,
  output logic done,
  output rsp_t rsp
);

  localparam int SLOTS = (MUTEX_COUNT < ID_SLOTS) ? MUTEX_COUNT : ID_SLOTS;

  logic req_vld;
  req_t req_q;
  rsp_t rsp_next;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      req_vld <= 1'b0;
      done    <= 1'b0;
    end else begin
      req_vld <= start;
      done    <= req_vld;
    end
  end

  always_ff @(posedge clk) begin
    req_q <= req;
    rsp   <= rsp_next;
  end

  omfw_table #(.SLOTS(SLOTS)) u_table (
    .clk (clk),
    .rst (rst),
    .vld (req_vld),
    .req (req_q),
    .rsp (rsp_next)
  );

endmodule

FILE: hw/rtl/omfw_alloc.sv
module omfw_alloc import omfw_pkg::*; #(
  parameter int SLOTS = 16,
  parameter int IW    = 4
) (
  input  logic [SLOTS-1:0] used,
  output logic             found,
  output logic [IW-1:0]    idx
);

  always_comb begin
    found = 1'b0;
    idx   = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!used[i]) begin
        found = 1'b1;
        idx   = IW'(i);
      end
    end
  end

endmodule

FILE: hw/rtl/omfw_table.sv
module omfw_table import omfw_pkg::*; #(
  parameter int SLOTS = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic vld,
  input  req_t req,
  output rsp_t rsp
);

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  logic [SLOTS-1:0]  in_use;
  logic signed [5:0] lock_count [SLOTS];
  logic [5:0]        owner_task [SLOTS];
  logic [4:0]        wait_head  [SLOTS];
  logic [4:0]        wait_tail  [SLOTS];
  logic [4:0]        wait_link  [32];

  logic          free_found;
  logic [IW-1:0] free_idx;

  logic [IW-1:0]     m_idx;
  logic              alloc;
  logic signed [5:0] cur_count;
  logic [5:0]        cur_owner;
  logic [4:0]        cur_head;
  logic [4:0]        cur_tail;
  logic              owner_hit;
  logic signed [5:0] dec_count;
  logic signed [5:0] inc_count;

  logic              row_we;
  logic [IW-1:0]     row_idx;
  logic              row_use;
  logic signed [5:0] row_count;
  logic [5:0]        row_owner;
  logic              head_we;
  logic [4:0]        head_val;
  logic              tail_we;
  logic              link_tail_we;
  logic              link_caller_we;

  omfw_alloc #(.SLOTS(SLOTS), .IW(IW)) u_alloc (
    .used  (in_use),
    .found (free_found),
    .idx   (free_idx)
  );

  assign m_idx     = IW'(req.mutex_id);
  assign alloc     = (32'(req.mutex_id) < SLOTS) && in_use[m_idx];
  assign cur_count = lock_count[m_idx];
  assign cur_owner = owner_task[m_idx];
  assign cur_head  = wait_head[m_idx];
  assign cur_tail  = wait_tail[m_idx];
  assign owner_hit = (cur_owner == {1'b0, req.caller_task});
  assign dec_count = cur_count - COUNT_FREE;
  assign inc_count = cur_count + COUNT_FREE;

  always_comb begin
    rsp            = '0;
    rsp.status     = ST_OK;
    row_we         = 1'b0;
    row_idx        = m_idx;
    row_use        = 1'b1;
    row_count      = cur_count;
    row_owner      = cur_owner;
    head_we        = 1'b0;
    head_val       = req.caller_task;
    tail_we        = 1'b0;
    link_tail_we   = 1'b0;
    link_caller_we = 1'b0;
    if (req.op != OP_CREATE && !alloc) begin
      rsp.status = ST_NOT_ALLOC;
    end else begin
      unique case (req.op)
        OP_CREATE: begin
          if (!free_found) begin
            rsp.status = ST_NONE_FREE;
          end else begin
            row_we         = 1'b1;
            row_idx        = free_idx;
            row_count      = COUNT_FREE;
            row_owner      = OWNER_NONE;
            rsp.created_id = 4'(free_idx);
          end
        end
        OP_DESTROY: begin
          if (!owner_hit) begin
            rsp.status = ST_NOT_OWNER;
          end else if (cur_count < COUNT_ZERO) begin
            rsp.status = ST_HAS_WAITERS;
          end else begin
            row_we    = 1'b1;
            row_use   = 1'b0;
            row_count = COUNT_FREE;
            row_owner = OWNER_NONE;
          end
        end
        OP_LOCK: begin
          if (cur_count <= COUNT_ZERO && owner_hit) begin
            rsp.status = ST_ALREADY_YOURS;
          end else if (cur_count == COUNT_MIN) begin
            rsp.status = ST_HAS_WAITERS;
          end else begin
            row_we    = 1'b1;
            row_count = dec_count;
            if (dec_count < COUNT_ZERO) begin
              rsp.blocked    = 1'b1;
              head_we        = (dec_count == COUNT_ONE_WAITER);
              link_tail_we   = (dec_count != COUNT_ONE_WAITER) &&
                               (cur_tail != req.caller_task);
              tail_we        = 1'b1;
              link_caller_we = 1'b1;
            end else begin
              row_owner = {1'b0, req.caller_task};
            end
          end
        end
        OP_UNLOCK: begin
          if (!owner_hit) begin
            rsp.status = ST_NOT_OWNER;
          end else if (cur_count > COUNT_ZERO) begin
            rsp.status = ST_NOT_LOCKED;
          end else begin
            row_we    = 1'b1;
            row_count = inc_count;
            if (inc_count <= COUNT_ZERO) begin
              head_we         = 1'b1;
              head_val        = wait_link[cur_head];
              row_owner       = {1'b0, cur_head};
              rsp.woken_valid = 1'b1;
              rsp.woken_task  = cur_head;
            end
          end
        end
        default: begin
          rsp.status = ST_NOT_ALLOC;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_use <= '0;
      for (int i = 0; i < SLOTS; i++) begin
        lock_count[i] <= COUNT_FREE;
        owner_task[i] <= OWNER_NONE;
      end
    end else if (vld && row_we) begin
      in_use[row_idx]     <= row_use;
      lock_count[row_idx] <= row_count;
      owner_task[row_idx] <= row_owner;
    end
  end

  always_ff @(posedge clk) begin
    if (vld) begin
      if (head_we) begin
        wait_head[m_idx] <= head_val;
      end
      if (tail_we) begin
        wait_tail[m_idx] <= req.caller_task;
      end
      // skip the old tail's link when the old tail is the caller
      if (link_tail_we) begin
        wait_link[cur_tail] <= req.caller_task;
      end
      if (link_caller_we) begin
        wait_link[req.caller_task] <= 5'd0;
      end
    end
  end

endmodule

FILE: sim/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import omfw_pkg::*;

  localparam int MUTEX_SLOTS = 16;
  localparam int TASK_SLOTS = 32;
  localparam int RANDOM_WORDS = 640;
  localparam int STALL_LIMIT = 200;
  localparam int DRAIN_CYCLES = 8;

  class mutex_table_shadow;
    bit                in_use[MUTEX_SLOTS];
    logic signed [5:0] lock_count[MUTEX_SLOTS];
    logic [5:0]        owner[MUTEX_SLOTS];
    logic [4:0]        head[MUTEX_SLOTS];
    logic [4:0]        tail[MUTEX_SLOTS];
    logic [4:0]        next_waiter[TASK_SLOTS];
    bit                waiting[TASK_SLOTS];
    rsp_t              expected_replies[$];
    int                last_created;
    int                mismatches;

    function void clear_slot(int m);
      in_use[m] = 1'b0;
      lock_count[m] = COUNT_FREE;
      owner[m] = OWNER_NONE;
    endfunction

    function void reset_state();
      for (int i = 0; i < MUTEX_SLOTS; i++) begin
        clear_slot(i);
        head[i] = '0;
        tail[i] = '0;
      end
      for (int i = 0; i < TASK_SLOTS; i++) begin
        next_waiter[i] = '0;
        waiting[i] = 1'b0;
      end
      expected_replies.delete();
      last_created = -1;
      mismatches = 0;
    endfunction

    function void take_request(req_t r);
      rsp_t       want;
      int         m;
      int         slot;
      logic [5:0] who;
      logic [4:0] p;
      want = '0;
      want.status = ST_OK;
      m = r.mutex_id;
      who = {1'b0, r.caller_task};
      slot = -1;
      if (r.op == OP_CREATE) begin
        for (int i = MUTEX_SLOTS - 1; i >= 0; i--)
          if (!in_use[i]) slot = i;
        last_created = slot;
        if (slot < 0) begin
          want.status = ST_NONE_FREE;
        end else begin
          clear_slot(slot);
          in_use[slot] = 1'b1;
          want.created_id = 4'(slot);
        end
      end else if (m >= MUTEX_SLOTS || !in_use[m]) begin
        want.status = ST_NOT_ALLOC;
      end else if (r.op == OP_DESTROY) begin
        if (owner[m] != who) want.status = ST_NOT_OWNER;
        else if (lock_count[m] < COUNT_ZERO) want.status = ST_HAS_WAITERS;
        else clear_slot(m);
      end else if (r.op == OP_LOCK) begin
        if (lock_count[m] <= COUNT_ZERO && owner[m] == who) begin
          want.status = ST_ALREADY_YOURS;
        end else if (lock_count[m] <= COUNT_MIN) begin
          want.status = ST_HAS_WAITERS;
        end else begin
          lock_count[m] = lock_count[m] - 6'sd1;
          if (lock_count[m] < COUNT_ZERO) begin
            if (lock_count[m] == COUNT_ONE_WAITER) head[m] = r.caller_task;
            else next_waiter[tail[m]] = r.caller_task;
            tail[m] = r.caller_task;
            next_waiter[r.caller_task] = '0;
            waiting[r.caller_task] = 1'b1;
            want.blocked = 1'b1;
          end else begin
            owner[m] = who;
          end
        end
      end else begin
        if (owner[m] != who) begin
          want.status = ST_NOT_OWNER;
        end else if (lock_count[m] > COUNT_ZERO) begin
          want.status = ST_NOT_LOCKED;
        end else begin
          lock_count[m] = lock_count[m] + 6'sd1;
          if (lock_count[m] <= COUNT_ZERO) begin
            p = head[m];
            head[m] = next_waiter[p];
            owner[m] = {1'b0, p};
            waiting[p] = 1'b0;
            want.woken_valid = 1'b1;
            want.woken_task = p;
          end
        end
      end
      expected_replies.push_back(want);
    endfunction

    function void report(string what, rsp_t want, rsp_t got);
      mismatches++;
      if (mismatches <= 10)
        $display("%s: expected st=%0d blk=%0d id=%0d wake=%0d/%0d, %s",
                 what, want.status, want.blocked, want.created_id,
                 want.woken_valid, want.woken_task,
                 $sformatf("got st=%0d blk=%0d id=%0d wake=%0d/%0d",
                           got.status, got.blocked, got.created_id,
                           got.woken_valid, got.woken_task));
    endfunction

    function void match_response(rsp_t got);
      rsp_t want;
      if (expected_replies.size() == 0) begin
        report("unexpected word", '0, got);
      end else begin
        want = expected_replies.pop_front();
        if (got.status !== want.status || got.blocked !== want.blocked ||
            got.created_id !== want.created_id ||
            got.woken_valid !== want.woken_valid ||
            got.woken_task !== want.woken_task)
          report("mismatch", want, got);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  req_t req = '0;
  logic done;
  rsp_t rsp;

  mutex_table_shadow shadow = new;
  int burst_left = 0;
  int stall_cycles = 0;

  owned_mutex_fifo_waiters #(.MUTEX_COUNT(MUTEX_SLOTS)) DUT (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .req(req),
    .done(done),
    .rsp(rsp)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (done === 1'b1) shadow.match_response(rsp);
  end

  always @(posedge clk) begin
    if ((start && !busy) || done) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic req_t make_req(op_e op, int m, int who);
    req_t r;
    r.op = op;
    r.mutex_id = 4'(m);
    r.caller_task = 5'(who);
    return r;
  endfunction

  task automatic send_word(input req_t r);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 48);
      if ($urandom_range(0, 3) != 0) begin
        gap = $urandom_range(1, 12);
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    start <= 1'b1;
    req <= r;
    do @(posedge clk); while (busy !== 1'b0);
    shadow.take_request(r);
  endtask

  function automatic req_t pick_word();
    int roll;
    int m;
    int who;
    int boss;
    int live[$];
    roll = $urandom_range(0, 99);
    for (int i = 0; i < MUTEX_SLOTS; i++)
      if (shadow.in_use[i]) live.push_back(i);
    if (live.size() == 0) m = -1;
    else if ($urandom_range(0, 1) != 0) m = live[0];
    else m = live[$urandom_range(0, live.size() - 1)];
    who = $urandom_range(0, TASK_SLOTS - 1);
    for (int k = 0; k < 8 && shadow.waiting[who]; k++) who = $urandom_range(0, TASK_SLOTS - 1);
    if (roll < 8)
      return make_req(op_e'($urandom_range(0, 3)), $urandom_range(0, 15), $urandom_range(0, 31));
    if (m < 0 || roll < 18) return make_req(OP_CREATE, $urandom_range(0, 15), who);
    boss = (shadow.owner[m] != OWNER_NONE && $urandom_range(0, 9) != 0) ?
           int'(shadow.owner[m][4:0]) : $urandom_range(0, TASK_SLOTS - 1);
    if (roll < 24) return make_req(OP_DESTROY, m, boss);
    if (roll < 60) return make_req(OP_LOCK, m, who);
    return make_req(OP_UNLOCK, m, boss);
  endfunction

  // fill one mutex past its queue limit, then hand it down the whole queue
  task automatic flood_queue();
    int m;
    int boss;
    int pick;
    int hold;
    int order[TASK_SLOTS];
    send_word(make_req(OP_CREATE, 0, 0));
    m = (shadow.last_created < 0) ? 0 : shadow.last_created;
    boss = $urandom_range(0, TASK_SLOTS - 1);
    for (int j = 0; j < TASK_SLOTS; j++) order[j] = j;
    for (int j = TASK_SLOTS - 1; j > 0; j--) begin
      pick = $urandom_range(0, j);
      hold = order[j];
      order[j] = order[pick];
      order[pick] = hold;
    end
    send_word(make_req(OP_LOCK, m, boss));
    for (int j = 0; j < TASK_SLOTS; j++) send_word(make_req(OP_LOCK, m, order[j]));
    repeat (2) send_word(make_req(OP_LOCK, m, (boss + 1) % TASK_SLOTS));
    while (shadow.lock_count[m] <= COUNT_ZERO)
      send_word(make_req(OP_UNLOCK, m, shadow.owner[m][4:0]));
    send_word(make_req(OP_DESTROY, m, shadow.owner[m][4:0]));
  endtask

  initial begin
    shadow.reset_state();
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    send_word(make_req(OP_LOCK, 15, 31));
    send_word(make_req(OP_DESTROY, 9, 0));
    send_word(make_req(OP_UNLOCK, 0, 0));
    send_word(make_req(OP_CREATE, 15, 31));
    send_word(make_req(OP_CREATE, 0, 0));
    send_word(make_req(OP_DESTROY, 1, 4));
    send_word(make_req(OP_LOCK, 0, 31));
    send_word(make_req(OP_LOCK, 0, 31));
    send_word(make_req(OP_LOCK, 0, 0));
    send_word(make_req(OP_LOCK, 0, 17));
    send_word(make_req(OP_UNLOCK, 0, 0));
    send_word(make_req(OP_DESTROY, 0, 31));
    send_word(make_req(OP_DESTROY, 0, 17));
    send_word(make_req(OP_UNLOCK, 0, 31));
    send_word(make_req(OP_UNLOCK, 0, 0));
    send_word(make_req(OP_UNLOCK, 0, 17));
    send_word(make_req(OP_UNLOCK, 0, 17));
    send_word(make_req(OP_LOCK, 0, 17));
    send_word(make_req(OP_DESTROY, 0, 17));
    send_word(make_req(OP_LOCK, 0, 17));
    send_word(make_req(OP_CREATE, 7, 10));
    send_word(make_req(OP_UNLOCK, 1, 31));

    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if (n == RANDOM_WORDS / 3 || n == 2 * RANDOM_WORDS / 3) flood_queue();
      send_word(pick_word());
    end

    start <= 1'b0;
    while (shadow.expected_replies.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (shadow.mismatches == 0 && shadow.expected_replies.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hw/rtl/omfw_pkg.sv
hw/rtl/omfw_alloc.sv
hw/rtl/omfw_table.sv
hw/rtl/owned_mutex_fifo_waiters.sv
sim/tb_top.sv
